// ===== sv/bswe_pkg.sv =====
`default_nettype none

package bswe_pkg;

  localparam int DEF_MAX_VERTICES = 65536;
  localparam int DEF_MAX_LEVELS   = 6;
  localparam int DEF_COEFF_WIDTH  = 32;

  localparam int IDX_W   = 16;
  localparam int END_W   = 17;
  localparam int WGT_W   = 18;
  localparam int CFG_W   = 17;
  localparam int CFGI_W  = 3;
  localparam int OUT_W   = 32;
  localparam int IN_C_W  = 32;

  localparam logic [2:0] MODE_LOAD     = 3'd0;
  localparam logic [2:0] MODE_FWD      = 3'd1;
  localparam logic [2:0] MODE_INV      = 3'd2;
  localparam logic [2:0] MODE_FWD_LIFT = 3'd3;
  localparam logic [2:0] MODE_INV_LIFT = 3'd4;
  localparam logic [2:0] MODE_READ     = 3'd5;

  localparam logic [CFGI_W-1:0] CFG_LEVEL_COUNT = 3'd0;

  localparam logic [6:0][END_W-1:0] LEVEL_END_RST = {
    17'd40962, 17'd10242, 17'd2562, 17'd642, 17'd162, 17'd42, 17'd12
  };

  typedef struct packed {
    logic signed [WGT_W-1:0] weight;
    logic [IDX_W-1:0]        parent_a;
    logic [IDX_W-1:0]        parent_b;
    logic [IDX_W-1:0]        face_a;
    logic [IDX_W-1:0]        face_b;
    logic [IDX_W-1:0]        edge_a;
    logic [IDX_W-1:0]        edge_b;
    logic [IDX_W-1:0]        edge_c;
    logic [IDX_W-1:0]        edge_d;
  } vrec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LVL,
    ST_P_REC,
    ST_P_RD,
    ST_P_WR,
    ST_L_REC,
    ST_L_MUL,
    ST_L_LFT,
    ST_L_PA,
    ST_L_PBR,
    ST_L_PB,
    ST_NEXT,
    ST_DONE
  } bswe_state_t;

endpackage

`default_nettype wire

// ===== sv/butterfly_sphere_wavelet_engine_top.sv =====
// Butterfly subdivision wavelet engine for a spherical mesh, in place.
// Input channel (in_valid/in_stall) carries one command word: load a vertex
// record, run one of four transforms, or read a coefficient. Result channel
// (out_valid/out_stall) returns one word for a read or a finished run and
// none for a load. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_wdata), to be used only while the engine is idle; the engine itself
// does not enforce this. A load writes its record and coefficient when taken.
// A read registers the coefficient, then the result word. A run walks every
// vertex of every selected level, reading each neighbour through the single
// read port of the coefficient memory. No further command is taken until
// the run word is produced. Reset clears the control state and restores the
// configuration defaults; the memories keep whatever they hold and must be
// loaded before use. A stalled result word is held in the output register;
// loads continue to be taken, but a read or run waits until the output
// register drains.
`default_nettype none

module butterfly_sphere_wavelet_engine_top
  import bswe_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_LEVELS   = DEF_MAX_LEVELS,
  parameter int COEFF_WIDTH  = DEF_COEFF_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [2:0]               in_mode,
  input  wire logic [IDX_W-1:0]         in_vertex_index,
  input  wire logic signed [IN_C_W-1:0] in_coeff_value,
  input  wire logic signed [WGT_W-1:0]  in_lift_weight,
  input  wire logic [IDX_W-1:0]         in_parent_a,
  input  wire logic [IDX_W-1:0]         in_parent_b,
  input  wire logic [IDX_W-1:0]         in_face_a,
  input  wire logic [IDX_W-1:0]         in_face_b,
  input  wire logic [IDX_W-1:0]         in_edge_a,
  input  wire logic [IDX_W-1:0]         in_edge_b,
  input  wire logic [IDX_W-1:0]         in_edge_c,
  input  wire logic [IDX_W-1:0]         in_edge_d,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [OUT_W-1:0]       out_read_value,
  output logic                          out_run_done,
  input  wire logic                     cfg_we,
  input  wire logic [CFGI_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_wdata
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = COEFF_WIDTH;
  localparam int XW = (CW > 32) ? CW : 32;
  localparam int PW = CW + 5;
  localparam int MW = CW + 18;
  localparam logic [20:0] MaxV  = 21'(MAX_VERTICES);
  localparam logic [2:0]  MaxLv = 3'(MAX_LEVELS);

  bswe_state_t state_r, state_nxt;

  logic [2:0]       level_count_r;
  logic [END_W-1:0] level_end_r [7];

  logic [CW-1:0] coef_mem [MAX_VERTICES];
  vrec_t         rec_mem  [MAX_VERTICES];

  logic          coef_we, coef_re;
  logic [AW-1:0] coef_waddr, coef_raddr;
  logic [CW-1:0] coef_wdata, coef_rdata_r;
  logic          rec_we, rec_re;
  logic [AW-1:0] rec_waddr, rec_raddr;
  vrec_t         rec_wdata, rec_rdata_r;

  logic             fwd_r, lifted_r, phase_r, rd_ok_r, nb_ok_r, neg_r;
  logic [2:0]       lvl_r, n_r;
  logic [END_W-1:0] cursor_r, end_r;
  logic [3:0]       k_r;
  logic signed [PW-1:0]   acc_r;
  logic [MW-1:0]          prod_r;
  logic signed [CW+2:0]   lift_r;
  logic                   out_valid_r, out_run_done_r;
  logic signed [OUT_W-1:0] out_value_r;

  logic             in_acc, res_mode;
  logic [2:0]       n_sel;
  logic [END_W-1:0] lvl_s, lvl_e, cursor_inc;
  logic [IDX_W-1:0] nb_idx;
  logic signed [CW-1:0] c_s;
  logic signed [PW-1:0] term, q;
  logic signed [PW:0]   pred_sum;
  logic signed [CW+3:0] lift_sum;
  logic signed [XW-1:0] load_x, read_x;
  logic [CW-1:0]        cm;
  logic [WGT_W-1:0]     wm;
  logic [MW-1:0]        prod_rnd;
  logic [CW+1:0]        mag;
  logic                 last_vtx;

  function automatic logic in_rng(input logic [END_W-1:0] x);
    return {4'b0, x} < MaxV;
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [END_W-1:0] x);
    return AW'(x);
  endfunction

  function automatic logic [END_W-1:0] clamp_end(input logic [END_W-1:0] x);
    return ({4'b0, x} > MaxV) ? MaxV[END_W-1:0] : x;
  endfunction

  function automatic logic [CW-1:0] sat_pred(input logic signed [PW:0] x);
    if (x[PW:CW-1] == {(PW-CW+2){x[PW]}}) return x[CW-1:0];
    return x[PW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  function automatic logic [CW-1:0] sat_lift(input logic signed [CW+3:0] x);
    if (x[CW+3:CW-1] == {5{x[CW+3]}}) return x[CW-1:0];
    return x[CW+3] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  function automatic logic [CW-1:0] sat_load(input logic signed [XW-1:0] x);
    if (x[XW-1:CW-1] == {(XW-CW+1){x[XW-1]}}) return x[CW-1:0];
    return x[XW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic signed [XW-1:0] x);
    if (x[XW-1:OUT_W-1] == {(XW-OUT_W+1){x[XW-1]}}) return x[OUT_W-1:0];
    return x[XW-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
  endfunction

  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[coef_waddr] <= coef_wdata;
    if (coef_re) coef_rdata_r <= coef_mem[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_waddr] <= rec_wdata;
    if (rec_re) rec_rdata_r <= rec_mem[rec_raddr];
  end

  assign res_mode = (in_mode == MODE_FWD) || (in_mode == MODE_INV) ||
                    (in_mode == MODE_FWD_LIFT) || (in_mode == MODE_INV_LIFT) ||
                    (in_mode == MODE_READ);
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall && res_mode);
  assign in_acc   = in_valid && !in_stall;

  assign n_sel      = (level_count_r > MaxLv) ? MaxLv : level_count_r;
  assign lvl_s      = clamp_end(level_end_r[lvl_r - 3'd1]);
  assign lvl_e      = clamp_end(level_end_r[lvl_r]);
  assign cursor_inc = cursor_r + 1'b1;
  assign last_vtx   = !(cursor_inc < end_r);

  assign c_s = coef_rdata_r;

  always_comb begin
    case (k_r[2:0])
      3'd0:    nb_idx = rec_rdata_r.parent_a;
      3'd1:    nb_idx = rec_rdata_r.parent_b;
      3'd2:    nb_idx = rec_rdata_r.face_a;
      3'd3:    nb_idx = rec_rdata_r.face_b;
      3'd4:    nb_idx = rec_rdata_r.edge_a;
      3'd5:    nb_idx = rec_rdata_r.edge_b;
      3'd6:    nb_idx = rec_rdata_r.edge_c;
      default: nb_idx = rec_rdata_r.edge_d;
    endcase
  end

  // Weighted term of the neighbour read in the previous cycle.
  always_comb begin
    term = '0;
    if (nb_ok_r) begin
      case (k_r)
        4'd1, 4'd2: term = PW'(c_s) <<< 3;
        4'd3, 4'd4: term = PW'(c_s) <<< 1;
        default:    term = -PW'(c_s);
      endcase
    end
  end

  assign q        = (acc_r + PW'(8)) >>> 4;
  assign pred_sum = fwd_r ? ((PW+1)'(c_s) - (PW+1)'(q)) : ((PW+1)'(c_s) + (PW+1)'(q));
  assign lift_sum = (CW+4)'(c_s) + (CW+4)'(lift_r);
  assign load_x   = XW'(in_coeff_value);
  assign read_x   = XW'(c_s);

  assign cm       = c_s[CW-1] ? CW'(-c_s) : CW'(c_s);
  assign wm       = rec_rdata_r.weight[WGT_W-1] ? WGT_W'(-rec_rdata_r.weight)
                                                : WGT_W'(rec_rdata_r.weight);
  assign prod_rnd = prod_r + MW'(32'h8000);
  assign mag      = prod_rnd[MW-1:16];

  always_comb begin
    state_nxt  = state_r;
    coef_we    = 1'b0;
    coef_waddr = to_addr(cursor_r);
    coef_wdata = sat_pred(pred_sum);
    coef_re    = 1'b0;
    coef_raddr = to_addr(cursor_r);
    rec_we     = 1'b0;
    rec_waddr  = to_addr({1'b0, in_vertex_index});
    rec_wdata  = '{in_lift_weight, in_parent_a, in_parent_b, in_face_a, in_face_b,
                   in_edge_a, in_edge_b, in_edge_c, in_edge_d};
    rec_re     = 1'b0;
    rec_raddr  = to_addr(cursor_r);
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_mode)
            MODE_LOAD: begin
              coef_we    = in_rng({1'b0, in_vertex_index});
              rec_we     = in_rng({1'b0, in_vertex_index});
              coef_waddr = to_addr({1'b0, in_vertex_index});
              coef_wdata = sat_load(load_x);
            end
            MODE_FWD, MODE_INV, MODE_FWD_LIFT, MODE_INV_LIFT: begin
              state_nxt = (n_sel == 3'd0) ? ST_DONE : ST_LVL;
            end
            MODE_READ: begin
              coef_re    = in_rng({1'b0, in_vertex_index});
              coef_raddr = to_addr({1'b0, in_vertex_index});
              state_nxt  = ST_READ;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      ST_LVL: begin
        if (!(lvl_s < lvl_e)) state_nxt = ST_NEXT;
        else if (fwd_r ? !phase_r : (!lifted_r || phase_r)) state_nxt = ST_P_REC;
        else state_nxt = ST_L_REC;
      end
      ST_P_REC: begin
        rec_re    = 1'b1;
        state_nxt = ST_P_RD;
      end
      ST_P_RD: begin
        if (k_r == 4'd8) begin
          coef_re   = 1'b1;
          state_nxt = ST_P_WR;
        end else begin
          coef_re    = in_rng({1'b0, nb_idx});
          coef_raddr = to_addr({1'b0, nb_idx});
        end
      end
      ST_P_WR: begin
        coef_we   = 1'b1;
        state_nxt = last_vtx ? ST_NEXT : ST_P_REC;
      end
      ST_L_REC: begin
        rec_re    = 1'b1;
        coef_re   = 1'b1;
        state_nxt = ST_L_MUL;
      end
      ST_L_MUL: state_nxt = ST_L_LFT;
      ST_L_LFT: begin
        coef_re    = in_rng({1'b0, rec_rdata_r.parent_a});
        coef_raddr = to_addr({1'b0, rec_rdata_r.parent_a});
        state_nxt  = ST_L_PA;
      end
      ST_L_PA: begin
        coef_we    = nb_ok_r;
        coef_waddr = to_addr({1'b0, rec_rdata_r.parent_a});
        coef_wdata = sat_lift(lift_sum);
        state_nxt  = ST_L_PBR;
      end
      ST_L_PBR: begin
        coef_re    = in_rng({1'b0, rec_rdata_r.parent_b});
        coef_raddr = to_addr({1'b0, rec_rdata_r.parent_b});
        state_nxt  = ST_L_PB;
      end
      ST_L_PB: begin
        coef_we    = nb_ok_r;
        coef_waddr = to_addr({1'b0, rec_rdata_r.parent_b});
        coef_wdata = sat_lift(lift_sum);
        state_nxt  = last_vtx ? ST_NEXT : ST_L_REC;
      end
      ST_NEXT: begin
        if (lifted_r && !phase_r) state_nxt = ST_LVL;
        else if (fwd_r ? (lvl_r == 3'd1) : (lvl_r == n_r)) state_nxt = ST_DONE;
        else state_nxt = ST_LVL;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_count_r <= '0;
      for (int i = 0; i < 7; i++) level_end_r[i] <= LEVEL_END_RST[i];
    end else if (cfg_we) begin
      if (cfg_index == CFG_LEVEL_COUNT) level_count_r <= cfg_wdata[2:0];
      else level_end_r[cfg_index - 3'd1] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r    <= 1'b0;
      lifted_r <= 1'b0;
      phase_r  <= 1'b0;
      lvl_r    <= '0;
      n_r      <= '0;
      cursor_r <= '0;
      end_r    <= '0;
      k_r      <= '0;
      rd_ok_r  <= 1'b0;
      nb_ok_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            fwd_r    <= (in_mode == MODE_FWD) || (in_mode == MODE_FWD_LIFT);
            lifted_r <= (in_mode == MODE_FWD_LIFT) || (in_mode == MODE_INV_LIFT);
            phase_r  <= 1'b0;
            n_r      <= n_sel;
            lvl_r    <= ((in_mode == MODE_FWD) || (in_mode == MODE_FWD_LIFT)) ? n_sel : 3'd1;
            rd_ok_r  <= in_rng({1'b0, in_vertex_index});
          end
        end
        ST_LVL: begin
          cursor_r <= lvl_s;
          end_r    <= lvl_e;
        end
        ST_P_REC: k_r <= '0;
        ST_P_RD: begin
          if (k_r == 4'd8) nb_ok_r <= 1'b1;
          else begin
            nb_ok_r <= in_rng({1'b0, nb_idx});
            k_r     <= k_r + 4'd1;
          end
        end
        ST_P_WR: cursor_r <= cursor_inc;
        ST_L_LFT: nb_ok_r <= in_rng({1'b0, rec_rdata_r.parent_a});
        ST_L_PBR: nb_ok_r <= in_rng({1'b0, rec_rdata_r.parent_b});
        ST_L_PB:  cursor_r <= cursor_inc;
        ST_NEXT: begin
          if (lifted_r && !phase_r) phase_r <= 1'b1;
          else begin
            phase_r <= 1'b0;
            lvl_r   <= fwd_r ? (lvl_r - 3'd1) : (lvl_r + 3'd1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_P_REC) acc_r <= '0;
    else if ((state_r == ST_P_RD) && (k_r != 4'd0)) acc_r <= acc_r + term;
    if (state_r == ST_L_MUL) begin
      prod_r <= MW'(cm) * MW'(wm);
      neg_r  <= c_s[CW-1] ^ rec_rdata_r.weight[WGT_W-1] ^ !fwd_r;
    end
    if (state_r == ST_L_LFT) lift_r <= neg_r ? -(CW+3)'(mag) : (CW+3)'(mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_READ || state_r == ST_DONE) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      out_value_r    <= rd_ok_r ? sat_out(read_x) : '0;
      out_run_done_r <= 1'b0;
    end else if (state_r == ST_DONE) begin
      out_value_r    <= '0;
      out_run_done_r <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_run_done   = out_run_done_r;

  a_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_done |-> out_read_value == '0)
    else $error("run word carries a non-zero value");

  a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_P_WR || state_r == ST_L_PB) |-> cursor_r < end_r)
    else $error("vertex cursor past level end");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_mode == MODE_FWD || in_mode == MODE_INV) |=> state_r != ST_IDLE)
    else $error("run command did not start");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ || state_r == ST_DONE) |-> !out_valid_r)
    else $error("result word overwritten");

endmodule

`default_nettype wire
